// ===== src/deadline_sorted_timer_table_top_macros.svh =====
// Assertion macros used by the timer table top module.
`ifndef DEADLINE_SORTED_TIMER_TABLE_TOP_MACROS_SVH
`define DEADLINE_SORTED_TIMER_TABLE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define DSTT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dstt assertion failed");
`define DSTT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dstt implication failed");
`else
`define DSTT_ASSERT(label, prop)
`define DSTT_ASSERT_IMP(label, ante, cons)
`endif

`endif

// ===== src/dstt_pkg.sv =====
package dstt_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int ID_COUNT_DEF = 64;
    localparam int MAX_OUT      = 16;

    localparam logic [1:0] OP_APPLY  = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] MODE_ALWAYS   = 2'd0;
    localparam logic [1:0] MODE_NEVER    = 2'd1;
    localparam logic [1:0] MODE_AT_LEAST = 2'd2;
    localparam logic [1:0] MODE_AT_MOST  = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;
    localparam logic [1:0] ST_UNCHANGED  = 2'd3;

    localparam logic EV_APPLY  = 1'b0;
    localparam logic EV_REMOVE = 1'b1;

    localparam logic [31:0] ENDLESS = 32'hFFFF_FFFF;

    typedef struct packed {
        logic idl;
        logic dl;
        logic nx;
        logic pv;
    } mem_we_t;

    function automatic logic [31:0] remain(input logic [31:0] dl, input logic [31:0] now);
        logic [31:0] r;
        if (dl == ENDLESS) begin
            r = ENDLESS;
        end
        else if (dl > now) begin
            r = dl - now;
        end
        else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ===== src/dstt_ifs.sv =====
interface dstt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [5:0]  entry_id;
    logic [7:0]  level;
    logic [31:0] deadline;
    logic [1:0]  overwrite_mode;
    logic [31:0] current_tick;

    modport source (output valid, operation, entry_id, level, deadline, overwrite_mode,
                    current_tick, input ready);
    modport sink (input valid, operation, entry_id, level, deadline, overwrite_mode,
                  current_tick, output ready);
endinterface

interface dstt_rsp_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [5:0]  result_id;
    logic [31:0] remaining;
    logic [1:0]  status;
    logic        notify;
    logic        last;

    modport source (output valid, event_kind, result_id, remaining, status, notify, last,
                    input ready);
    modport sink (input valid, event_kind, result_id, remaining, status, notify, last,
                  output ready);
endinterface

interface dstt_cfg_if;
    logic valid;
    logic ready;
    logic notify_enable;

    modport source (output valid, notify_enable, input ready);
    modport sink (input valid, notify_enable, output ready);
endinterface

// ===== src/deadline_sorted_timer_table_top.sv =====
// Deadline-sorted timer table.
// Items arrive on req (operation, entry_id, level, deadline, overwrite_mode,
// current_tick) and results leave on rsp; both use valid/ready and move an item
// when valid and ready are high at a rising clock edge. The cfg channel writes
// notify_enable and is always ready; write it only while the block is idle.
// Entries live in one slot memory with a single registered read port,
// linked in deadline order, and every list step is one read of that memory.
// An apply searches the list for an active entry, walks it for the sorted insert,
// and then issues its queued link writes. A remove searches for the entry and
// then issues its link writes. A tick removes each expired entry from the head
// and ends with a final head check.
// The block takes one item at a time; req.ready is high while it is idle.
// Results wait in an output register, so a stalled receiver only holds the block
// when a second result is ready; the last result of an item carries last.
// After reset the table is empty, all slots are free and notify_enable is 1.
module deadline_sorted_timer_table_top
    import dstt_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int ID_COUNT = ID_COUNT_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    dstt_req_if.sink     req,
    dstt_rsp_if.source   rsp,
    dstt_cfg_if.sink     cfg
);

`include "deadline_sorted_timer_table_top_macros.svh"

    localparam int SW  = $clog2(SLOTS);
    localparam int PW  = SW + 1;
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int IW  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int TW  = $clog2(MAX_OUT + 1);
    localparam int NW  = 5;
    localparam int WSW = $clog2(NW);
    localparam logic [PW-1:0] NIL = {PW{1'b1}};

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_FIND_RD  = 13'b0000000000010,
        S_FIND_CHK = 13'b0000000000100,
        S_WALK_RD  = 13'b0000000001000,
        S_WALK_CHK = 13'b0000000010000,
        S_ADD_RD   = 13'b0000000100000,
        S_ADD_CHK  = 13'b0000001000000,
        S_ADD_LRD  = 13'b0000010000000,
        S_ADD_LCHK = 13'b0000100000000,
        S_WR       = 13'b0001000000000,
        S_TICK_RD  = 13'b0010000000000,
        S_TICK_CHK = 13'b0100000000000,
        S_EMIT     = 13'b1000000000000
    } state_t;

    typedef struct packed {
        mem_we_t       we;
        logic [SW-1:0] addr;
        logic [31:0]   dl;
        logic [PW-1:0] nx;
        logic [PW-1:0] pv;
    } wq_t;

    function automatic logic ptr_ok(input logic [PW-1:0] p);
        return 32'(p) < 32'(SLOTS);
    endfunction

    function automatic logic [PW-1:0] start_of(input logic [PW-1:0] p, input logic [PW-1:0] e);
        logic [PW-1:0] r;
        if (ptr_ok(p))
        begin
            r = p;
        end
        else if (ptr_ok(e))
        begin
            r = e;
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [5:0]  id_reg, id_next;
    logic [7:0]  lvl_reg, lvl_next;
    logic [31:0] dl_reg, dl_next;
    logic [1:0]  mode_reg, mode_next;
    logic [31:0] now_reg, now_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [CW-1:0] k_reg, k_next;
    logic          final_reg, final_next;
    logic          add_reg, add_next;
    logic [PW-1:0] s_reg, s_next;
    logic [PW-1:0] s_nx_reg, s_nx_next;
    logic [PW-1:0] s_pv_reg, s_pv_next;
    logic [PW-1:0] earliest_reg, earliest_next;
    logic [PW-1:0] free_head_reg, free_head_next;
    logic [PW-1:0] last_ins_reg, last_ins_next;
    logic [CW-1:0] count_reg, count_next;
    logic [ID_COUNT-1:0] active_reg, active_next;
    logic          notify_reg, notify_next;
    logic [TW-1:0] tick_n_reg, tick_n_next;
    logic          pend_reg, pend_next;
    logic          ret_tick_reg, ret_tick_next;
    logic [WSW-1:0] wstep_reg, wstep_next;
    wq_t           wq_reg [NW];
    wq_t           wq_next [NW];
    wq_t           wq_new [NW];
    logic          wq_load;
    logic          do_drop;

    logic          res_kind_reg, res_kind_next;
    logic [5:0]    res_id_reg, res_id_next;
    logic [31:0]   res_rem_reg, res_rem_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic          res_nt_reg, res_nt_next;

    logic          out_v_reg, out_v_next;
    logic          out_kind_reg;
    logic [5:0]    out_id_reg;
    logic [31:0]   out_rem_reg;
    logic [1:0]    out_st_reg;
    logic          out_nt_reg;
    logic          out_last_reg;
    logic          out_load;
    logic          out_last_val;
    logic          can_emit;

    logic          mem_rd_en;
    logic [SW-1:0] mem_rd_addr;
    logic [SW-1:0] mem_wr_addr;
    mem_we_t       mem_we;
    logic [31:0]   mem_wr_dl;
    logic [PW-1:0] mem_wr_nx;
    logic [PW-1:0] mem_wr_pv;
    logic [5:0]    rd_id;
    logic [7:0]    rd_level;
    logic [31:0]   rd_dl;
    logic [PW-1:0] rd_nx;
    logic [PW-1:0] rd_pv;
    logic [PW-1:0] drop_earliest;
    logic          id_in_range;

    dstt_slot_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .wr_addr  (mem_wr_addr),
        .we       (mem_we),
        .wr_id    (id_reg),
        .wr_level (lvl_reg),
        .wr_dl    (mem_wr_dl),
        .wr_next  (mem_wr_nx),
        .wr_prev  (mem_wr_pv),
        .rd_id    (rd_id),
        .rd_level (rd_level),
        .rd_dl    (rd_dl),
        .rd_next  (rd_nx),
        .rd_prev  (rd_pv)
    );

    assign can_emit      = !out_v_reg || rsp.ready;
    assign id_in_range   = 32'(req.entry_id) < 32'(ID_COUNT);
    assign drop_earliest = ptr_ok(rd_pv) ? earliest_reg : (ptr_ok(rd_nx) ? rd_nx : free_head_reg);

    always_comb
    begin
        logic          le;
        logic [PW-1:0] lk_n;
        logic [PW-1:0] lk_p;
        logic [PW-1:0] e;

        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        lvl_next       = lvl_reg;
        dl_next        = dl_reg;
        mode_next      = mode_reg;
        now_next       = now_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        final_next     = final_reg;
        add_next       = add_reg;
        s_next         = s_reg;
        s_nx_next      = s_nx_reg;
        s_pv_next      = s_pv_reg;
        earliest_next  = earliest_reg;
        free_head_next = free_head_reg;
        last_ins_next  = last_ins_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        notify_next    = notify_reg;
        tick_n_next    = tick_n_reg;
        pend_next      = pend_reg;
        ret_tick_next  = ret_tick_reg;
        wstep_next     = wstep_reg;
        res_kind_next  = res_kind_reg;
        res_id_next    = res_id_reg;
        res_rem_next   = res_rem_reg;
        res_st_next    = res_st_reg;
        res_nt_next    = res_nt_reg;
        out_load       = 1'b0;
        out_last_val   = 1'b1;
        wq_load        = 1'b0;
        do_drop        = 1'b0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = idx_reg[SW-1:0];
        mem_wr_addr    = s_reg[SW-1:0];
        mem_we         = '0;
        mem_wr_dl      = dl_reg;
        mem_wr_nx      = NIL;
        mem_wr_pv      = NIL;
        le             = 1'b0;
        lk_n           = NIL;
        lk_p           = NIL;
        e              = earliest_reg;
        for (int i = 0; i < NW; i++)
        begin
            wq_new[i] = '0;
        end

        if (cfg.valid)
        begin
            notify_next = cfg.notify_enable;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.operation;
                    id_next     = req.entry_id;
                    lvl_next    = req.level;
                    dl_next     = req.deadline;
                    mode_next   = req.overwrite_mode;
                    now_next    = req.current_tick;
                    k_next      = '0;
                    final_next  = 1'b0;
                    pend_next   = 1'b0;
                    tick_n_next = '0;
                    idx_next    = earliest_reg;
                    res_id_next = req.entry_id;
                    res_rem_next = '0;
                    res_nt_next = 1'b0;
                    case (req.operation)
                        OP_APPLY:
                        begin
                            res_kind_next = EV_APPLY;
                            if (!id_in_range)
                            begin
                                res_st_next = ST_NOT_ACTIVE;
                                state_next  = S_EMIT;
                            end
                            else if (active_reg[IW'(req.entry_id)])
                            begin
                                add_next   = 1'b0;
                                state_next = S_FIND_RD;
                            end
                            else if (!ptr_ok(free_head_reg))
                            begin
                                res_st_next = ST_FULL;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                add_next   = 1'b1;
                                s_next     = free_head_reg;
                                state_next = S_ADD_RD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            res_kind_next = EV_REMOVE;
                            if (id_in_range && active_reg[IW'(req.entry_id)])
                            begin
                                state_next = S_FIND_RD;
                            end
                            else
                            begin
                                res_st_next = ST_NOT_ACTIVE;
                                state_next  = S_EMIT;
                            end
                        end
                        OP_TICK:
                        begin
                            state_next = S_TICK_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FIND_RD:
            begin
                if (k_reg < count_reg && ptr_ok(idx_reg))
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_FIND_CHK;
                end
                else
                begin
                    res_st_next  = ST_NOT_ACTIVE;
                    res_rem_next = '0;
                    res_nt_next  = 1'b0;
                    state_next   = S_EMIT;
                end
            end

            S_FIND_CHK:
            begin
                if (rd_id == id_reg)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        do_drop       = 1'b1;
                        res_st_next   = ST_OK;
                        res_nt_next   = notify_reg;
                        ret_tick_next = 1'b0;
                        state_next    = S_WR;
                    end
                    else if (rd_dl == dl_reg || mode_reg == MODE_NEVER ||
                             (mode_reg == MODE_AT_LEAST && rd_level < lvl_reg) ||
                             (mode_reg == MODE_AT_MOST && rd_level > lvl_reg))
                    begin
                        res_st_next  = ST_UNCHANGED;
                        res_rem_next = remain(rd_dl, now_reg);
                        res_nt_next  = notify_reg;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        s_next     = idx_reg;
                        s_nx_next  = rd_nx;
                        s_pv_next  = rd_pv;
                        idx_next   = (rd_dl <= dl_reg) ? idx_reg : start_of(earliest_reg,
                                                                          earliest_reg);
                        k_next     = '0;
                        final_next = 1'b0;
                        state_next = S_WALK_RD;
                    end
                end
                else
                begin
                    idx_next   = rd_nx;
                    k_next     = k_reg + CW'(1);
                    state_next = S_FIND_RD;
                end
            end

            S_WALK_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_WALK_CHK;
            end

            S_WALK_CHK:
            begin
                if (final_reg || !ptr_ok(rd_nx) || dl_reg <= rd_dl)
                begin
                    wq_load       = 1'b1;
                    ret_tick_next = 1'b0;
                    wstep_next    = '0;
                    res_st_next   = ST_OK;
                    res_rem_next  = remain(dl_reg, now_reg);
                    res_nt_next   = notify_reg;
                    state_next    = S_WR;
                    le            = dl_reg <= rd_dl;
                    lk_n          = le ? idx_reg : NIL;
                    if (add_reg)
                    begin
                        lk_p = le ? rd_pv : idx_reg;
                        wq_new[0].we.nx = 1'b1;
                        wq_new[0].we.pv = 1'b1;
                        wq_new[0].addr  = s_reg[SW-1:0];
                        wq_new[0].nx    = lk_n;
                        wq_new[0].pv    = lk_p;
                        wq_new[1].we.pv = ptr_ok(lk_n);
                        wq_new[1].addr  = lk_n[SW-1:0];
                        wq_new[1].pv    = s_reg;
                        wq_new[2].we.nx = ptr_ok(lk_p);
                        wq_new[2].addr  = lk_p[SW-1:0];
                        wq_new[2].nx    = s_reg;
                        if (!ptr_ok(lk_p))
                        begin
                            earliest_next = s_reg;
                        end
                        count_next = count_reg + CW'(1);
                    end
                    else if (idx_reg == s_reg)
                    begin
                        wq_new[0].we.dl = 1'b1;
                        wq_new[0].addr  = s_reg[SW-1:0];
                        wq_new[0].dl    = dl_reg;
                    end
                    else
                    begin
                        e    = (earliest_reg == s_reg) ? s_nx_reg : earliest_reg;
                        lk_p = le ? ((idx_reg == s_nx_reg) ? s_pv_reg : rd_pv) : idx_reg;
                        wq_new[0].we.nx = ptr_ok(s_pv_reg);
                        wq_new[0].addr  = s_pv_reg[SW-1:0];
                        wq_new[0].nx    = s_nx_reg;
                        wq_new[1].we.pv = ptr_ok(s_nx_reg);
                        wq_new[1].addr  = s_nx_reg[SW-1:0];
                        wq_new[1].pv    = s_pv_reg;
                        wq_new[2].we.dl = 1'b1;
                        wq_new[2].we.nx = 1'b1;
                        wq_new[2].we.pv = 1'b1;
                        wq_new[2].addr  = s_reg[SW-1:0];
                        wq_new[2].dl    = dl_reg;
                        wq_new[2].nx    = lk_n;
                        wq_new[2].pv    = lk_p;
                        wq_new[3].we.pv = ptr_ok(lk_n);
                        wq_new[3].addr  = lk_n[SW-1:0];
                        wq_new[3].pv    = s_reg;
                        wq_new[4].we.nx = ptr_ok(lk_p);
                        wq_new[4].addr  = lk_p[SW-1:0];
                        wq_new[4].nx    = s_reg;
                        earliest_next   = ptr_ok(lk_p) ? e : s_reg;
                    end
                end
                else
                begin
                    idx_next   = rd_nx;
                    k_next     = k_reg + CW'(1);
                    final_next = (32'(k_reg) == 32'(SLOTS) - 32'd1);
                    state_next = S_WALK_RD;
                end
            end

            S_ADD_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = s_reg[SW-1:0];
                state_next  = S_ADD_CHK;
            end

            S_ADD_CHK:
            begin
                free_head_next              = rd_nx;
                active_next[IW'(id_reg)]    = 1'b1;
                mem_we.idl                  = 1'b1;
                mem_we.dl                   = 1'b1;
                state_next                  = S_ADD_LRD;
            end

            S_ADD_LRD:
            begin
                k_next     = '0;
                final_next = 1'b0;
                if (count_reg == '0)
                begin
                    wq_load         = 1'b1;
                    wq_new[0].we.nx = 1'b1;
                    wq_new[0].we.pv = 1'b1;
                    wq_new[0].addr  = s_reg[SW-1:0];
                    wq_new[0].nx    = NIL;
                    wq_new[0].pv    = NIL;
                    earliest_next   = s_reg;
                    last_ins_next   = s_reg;
                    count_next      = count_reg + CW'(1);
                    res_st_next     = ST_OK;
                    res_rem_next    = remain(dl_reg, now_reg);
                    res_nt_next     = notify_reg;
                    ret_tick_next   = 1'b0;
                    wstep_next      = '0;
                    state_next      = S_WR;
                end
                else if (ptr_ok(last_ins_reg))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = last_ins_reg[SW-1:0];
                    state_next  = S_ADD_LCHK;
                end
                else
                begin
                    idx_next      = start_of(earliest_reg, earliest_reg);
                    last_ins_next = s_reg;
                    state_next    = S_WALK_RD;
                end
            end

            S_ADD_LCHK:
            begin
                idx_next      = start_of((dl_reg >= rd_dl) ? last_ins_reg : earliest_reg,
                                         earliest_reg);
                last_ins_next = s_reg;
                state_next    = S_WALK_RD;
            end

            S_WR:
            begin
                mem_we      = wq_reg[wstep_reg].we;
                mem_wr_addr = wq_reg[wstep_reg].addr;
                mem_wr_dl   = wq_reg[wstep_reg].dl;
                mem_wr_nx   = wq_reg[wstep_reg].nx;
                mem_wr_pv   = wq_reg[wstep_reg].pv;
                if (32'(wstep_reg) == NW - 1)
                begin
                    wstep_next = '0;
                    state_next = ret_tick_reg ? S_TICK_RD : S_EMIT;
                end
                else
                begin
                    wstep_next = wstep_reg + WSW'(1);
                end
            end

            S_TICK_RD:
            begin
                if (32'(tick_n_reg) < MAX_OUT && count_reg != '0 && ptr_ok(earliest_reg))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = earliest_reg[SW-1:0];
                    idx_next    = earliest_reg;
                    state_next  = S_TICK_CHK;
                end
                else
                begin
                    state_next = pend_reg ? S_EMIT : S_IDLE;
                end
            end

            S_TICK_CHK:
            begin
                if (rd_dl == ENDLESS || rd_dl > now_reg)
                begin
                    state_next = pend_reg ? S_EMIT : S_IDLE;
                end
                else if (!pend_reg || can_emit)
                begin
                    out_load      = pend_reg;
                    out_last_val  = 1'b0;
                    res_kind_next = EV_REMOVE;
                    res_id_next   = rd_id;
                    res_rem_next  = '0;
                    res_st_next   = ST_OK;
                    res_nt_next   = notify_reg;
                    pend_next     = 1'b1;
                    tick_n_next   = tick_n_reg + TW'(1);
                    do_drop       = 1'b1;
                    ret_tick_next = 1'b1;
                    state_next    = S_WR;
                end
            end

            S_EMIT:
            begin
                if (can_emit)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_drop)
        begin
            wq_load         = 1'b1;
            wstep_next      = '0;
            wq_new[0].we.nx = ptr_ok(rd_pv);
            wq_new[0].addr  = rd_pv[SW-1:0];
            wq_new[0].nx    = rd_nx;
            wq_new[1].we.pv = ptr_ok(rd_nx);
            wq_new[1].addr  = rd_nx[SW-1:0];
            wq_new[1].pv    = rd_pv;
            wq_new[2].we.dl = 1'b1;
            wq_new[2].we.nx = 1'b1;
            wq_new[2].we.pv = 1'b1;
            wq_new[2].addr  = idx_reg[SW-1:0];
            wq_new[2].dl    = ENDLESS;
            wq_new[2].nx    = free_head_reg;
            wq_new[2].pv    = NIL;
            earliest_next   = drop_earliest;
            if (last_ins_reg == idx_reg)
            begin
                last_ins_next = drop_earliest;
            end
            if (32'(rd_id) < 32'(ID_COUNT))
            begin
                active_next[IW'(rd_id)] = 1'b0;
            end
            free_head_next = idx_reg;
            if (count_reg != '0)
            begin
                count_next = count_reg - CW'(1);
            end
        end

        for (int i = 0; i < NW; i++)
        begin
            wq_next[i] = wq_load ? wq_new[i] : wq_reg[i];
        end

        if (out_load)
        begin
            out_v_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            earliest_reg  <= '0;
            free_head_reg <= '0;
            last_ins_reg  <= '0;
            count_reg     <= '0;
            active_reg    <= '0;
            notify_reg    <= 1'b1;
            tick_n_reg    <= '0;
            pend_reg      <= 1'b0;
            ret_tick_reg  <= 1'b0;
            wstep_reg     <= '0;
            k_reg         <= '0;
            final_reg     <= 1'b0;
            add_reg       <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            earliest_reg  <= earliest_next;
            free_head_reg <= free_head_next;
            last_ins_reg  <= last_ins_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            notify_reg    <= notify_next;
            tick_n_reg    <= tick_n_next;
            pend_reg      <= pend_next;
            ret_tick_reg  <= ret_tick_next;
            wstep_reg     <= wstep_next;
            k_reg         <= k_next;
            final_reg     <= final_next;
            add_reg       <= add_next;
            out_v_reg     <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        lvl_reg       <= lvl_next;
        dl_reg        <= dl_next;
        mode_reg      <= mode_next;
        now_reg       <= now_next;
        idx_reg       <= idx_next;
        s_reg         <= s_next;
        s_nx_reg      <= s_nx_next;
        s_pv_reg      <= s_pv_next;
        res_kind_reg  <= res_kind_next;
        res_id_reg    <= res_id_next;
        res_rem_reg   <= res_rem_next;
        res_st_reg    <= res_st_next;
        res_nt_reg    <= res_nt_next;
        for (int i = 0; i < NW; i++)
        begin
            wq_reg[i] <= wq_next[i];
        end
        if (out_load)
        begin
            out_kind_reg <= res_kind_reg;
            out_id_reg   <= res_id_reg;
            out_rem_reg  <= res_rem_reg;
            out_st_reg   <= res_st_reg;
            out_nt_reg   <= res_nt_reg;
            out_last_reg <= out_last_val;
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_v_reg;
    assign rsp.event_kind = out_kind_reg;
    assign rsp.result_id  = out_id_reg;
    assign rsp.remaining  = out_rem_reg;
    assign rsp.status     = out_st_reg;
    assign rsp.notify     = out_nt_reg;
    assign rsp.last       = out_last_reg;

    `DSTT_ASSERT(a_count_range, count_reg <= CW'(SLOTS))
    `DSTT_ASSERT(a_tick_bound, 32'(tick_n_reg) <= MAX_OUT)
    `DSTT_ASSERT_IMP(a_no_overrun, out_load, !out_v_reg || rsp.ready)
    `DSTT_ASSERT_IMP(a_full_count, state_reg == S_IDLE && !ptr_ok(free_head_reg),
                     count_reg == CW'(SLOTS))

endmodule

// ===== src/dstt_slot_mem.sv =====
module dstt_slot_mem
    import dstt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(SLOTS)-1:0]     rd_addr,
    input  logic [$clog2(SLOTS)-1:0]     wr_addr,
    input  mem_we_t                      we,
    input  logic [5:0]                   wr_id,
    input  logic [7:0]                   wr_level,
    input  logic [31:0]                  wr_dl,
    input  logic [$clog2(SLOTS):0]       wr_next,
    input  logic [$clog2(SLOTS):0]       wr_prev,
    output logic [5:0]                   rd_id,
    output logic [7:0]                   rd_level,
    output logic [31:0]                  rd_dl,
    output logic [$clog2(SLOTS):0]       rd_next,
    output logic [$clog2(SLOTS):0]       rd_prev
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = SW + 1;
    localparam logic [PW-1:0] NIL = {PW{1'b1}};

    logic [5:0]    id_mem  [SLOTS];
    logic [7:0]    lvl_mem [SLOTS];
    logic [31:0]   dl_mem  [SLOTS];
    logic [PW-1:0] nx_mem  [SLOTS];
    logic [PW-1:0] pv_mem  [SLOTS];

    logic [SLOTS-1:0] dl_vld_reg;
    logic [SLOTS-1:0] nx_vld_reg;
    logic [SLOTS-1:0] pv_vld_reg;

    logic [5:0]    rd_id_reg;
    logic [7:0]    rd_level_reg;
    logic [31:0]   rd_dl_reg;
    logic [PW-1:0] rd_next_reg;
    logic [PW-1:0] rd_prev_reg;
    logic [PW-1:0] nx_dflt;

    // Before its first write, a slot links to the following slot of the initial free chain.
    assign nx_dflt = (32'(rd_addr) + 32'd1 < 32'(SLOTS)) ? (PW'(rd_addr) + PW'(1)) : NIL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_vld_reg <= '0;
            nx_vld_reg <= '0;
            pv_vld_reg <= '0;
        end
        else
        begin
            if (we.dl)
            begin
                dl_vld_reg[wr_addr] <= 1'b1;
            end
            if (we.nx)
            begin
                nx_vld_reg[wr_addr] <= 1'b1;
            end
            if (we.pv)
            begin
                pv_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we.idl)
        begin
            id_mem[wr_addr]  <= wr_id;
            lvl_mem[wr_addr] <= wr_level;
        end
        if (we.dl)
        begin
            dl_mem[wr_addr] <= wr_dl;
        end
        if (we.nx)
        begin
            nx_mem[wr_addr] <= wr_next;
        end
        if (we.pv)
        begin
            pv_mem[wr_addr] <= wr_prev;
        end
        if (rd_en)
        begin
            rd_id_reg    <= id_mem[rd_addr];
            rd_level_reg <= lvl_mem[rd_addr];
            rd_dl_reg    <= dl_vld_reg[rd_addr] ? dl_mem[rd_addr] : ENDLESS;
            rd_next_reg  <= nx_vld_reg[rd_addr] ? nx_mem[rd_addr] : nx_dflt;
            rd_prev_reg  <= pv_vld_reg[rd_addr] ? pv_mem[rd_addr] : NIL;
        end
    end

    assign rd_id    = rd_id_reg;
    assign rd_level = rd_level_reg;
    assign rd_dl    = rd_dl_reg;
    assign rd_next  = rd_next_reg;
    assign rd_prev  = rd_prev_reg;

endmodule

// ===== bench/deadline_sorted_timer_table_checker.sv =====
module deadline_sorted_timer_table_checker
    import dstt_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    dstt_req_if.sink     req,
    dstt_rsp_if.sink     rsp,
    dstt_cfg_if.sink     cfg,
    output int           errors,
    output int           pending,
    output int           results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = SLOTS_DEF;
    localparam int NID   = ID_COUNT_DEF;
    localparam logic [4:0] NONE = 5'h1F;

    typedef struct packed {
        logic        kind;
        logic [5:0]  id;
        logic [31:0] rem;
        logic [1:0]  status;
        logic        notify;
        logic        last;
    } timer_event_t;

    logic [5:0]  tbl_id [NSLOT];
    logic [7:0]  tbl_level [NSLOT];
    logic [31:0] tbl_deadline [NSLOT];
    logic [4:0]  tbl_next [NSLOT];
    logic [4:0]  tbl_prev [NSLOT];
    logic        id_active [NID];
    logic [4:0]  head_slot;
    logic [4:0]  free_slot;
    logic [4:0]  recent_slot;
    int          live_count;
    logic        notify_on;
    timer_event_t expected_events[$];

    function automatic bit valid_slot(logic [4:0] s);
        return s < NSLOT;
    endfunction

    function automatic logic [31:0] time_left(logic [31:0] dl, logic [31:0] now);
        if (dl == ENDLESS) return ENDLESS;
        return (dl > now) ? dl - now : 32'd0;
    endfunction

    function automatic logic [4:0] seek_position(logic [4:0] start, logic [31:0] dl);
        logic [4:0] s;
        s = valid_slot(start) ? start : head_slot;
        if (!valid_slot(s)) s = '0;
        for (int k = 0; k < NSLOT; k++) begin
            if (!valid_slot(tbl_next[s]) || dl <= tbl_deadline[s]) break;
            s = tbl_next[s];
        end
        return s;
    endfunction

    task automatic splice_in(logic [4:0] s, logic [4:0] at);
        logic [4:0] n;
        logic [4:0] p;
        if (tbl_deadline[s] <= tbl_deadline[at]) begin
            n = at;
            p = tbl_prev[at];
        end
        else begin
            n = NONE;
            p = at;
        end
        tbl_next[s] = n;
        tbl_prev[s] = p;
        if (valid_slot(n)) tbl_prev[n] = s;
        if (valid_slot(p)) tbl_next[p] = s;
        else head_slot = s;
    endtask

    task automatic release_slot(logic [4:0] s);
        logic [4:0] p;
        logic [4:0] n;
        p = tbl_prev[s];
        n = tbl_next[s];
        if (valid_slot(p)) tbl_next[p] = n;
        else head_slot = valid_slot(n) ? n : free_slot;
        if (valid_slot(n)) tbl_prev[n] = p;
        if (recent_slot == s) recent_slot = head_slot;
        id_active[tbl_id[s]] = 0;
        tbl_next[s] = free_slot;
        tbl_prev[s] = NONE;
        free_slot = s;
        tbl_deadline[s] = ENDLESS;
        if (live_count > 0) live_count--;
    endtask

    function automatic logic [4:0] locate_id(logic [5:0] id);
        logic [4:0] s;
        s = head_slot;
        for (int k = 0; k < live_count && k < NSLOT && valid_slot(s); k++) begin
            if (tbl_id[s] == id) return s;
            s = tbl_next[s];
        end
        return NONE;
    endfunction

    task automatic move_entry(logic [4:0] s, logic [7:0] lvl, logic [31:0] dl,
                              logic [1:0] mode, output logic [1:0] st);
        logic [4:0] at;
        st = ST_OK;
        if (tbl_deadline[s] == dl || mode == MODE_NEVER
            || (mode == MODE_AT_LEAST && tbl_level[s] < lvl)
            || (mode == MODE_AT_MOST && tbl_level[s] > lvl)) begin
            st = ST_UNCHANGED;
            return;
        end
        at = seek_position(tbl_deadline[s] <= dl ? s : head_slot, dl);
        tbl_deadline[s] = dl;
        if (at == s) return;
        if (head_slot == s) head_slot = tbl_next[s];
        if (valid_slot(tbl_prev[s])) tbl_next[tbl_prev[s]] = tbl_next[s];
        if (valid_slot(tbl_next[s])) tbl_prev[tbl_next[s]] = tbl_prev[s];
        splice_in(s, at);
    endtask

    task automatic insert_entry(logic [5:0] id, logic [7:0] lvl, logic [31:0] dl);
        logic [4:0] s;
        logic [4:0] start;
        s = free_slot;
        id_active[id] = 1;
        free_slot = tbl_next[s];
        tbl_id[s] = id;
        tbl_level[s] = lvl;
        tbl_deadline[s] = dl;
        start = (valid_slot(recent_slot) && dl >= tbl_deadline[recent_slot])
                ? recent_slot : head_slot;
        recent_slot = s;
        if (live_count > 0) begin
            splice_in(s, seek_position(start, dl));
        end
        else begin
            tbl_next[s] = NONE;
            tbl_prev[s] = NONE;
            head_slot = s;
        end
        live_count++;
    endtask

    task automatic push_event(logic kind, logic [5:0] id, logic [31:0] rem,
                              logic [1:0] st, logic nt);
        timer_event_t e;
        e = '{kind, id, rem, st, nt, 1'b0};
        expected_events.push_back(e);
    endtask

    task automatic predict_item(logic [1:0] op, logic [5:0] id, logic [7:0] lvl,
                                logic [31:0] dl, logic [1:0] mode, logic [31:0] now);
        logic [4:0] s;
        logic [1:0] st;
        int made;
        made = 0;
        if (op == OP_APPLY) begin
            if (id_active[id]) begin
                s = locate_id(id);
                if (!valid_slot(s)) begin
                    push_event(EV_APPLY, id, 32'd0, ST_NOT_ACTIVE, 1'b0);
                end
                else begin
                    move_entry(s, lvl, dl, mode, st);
                    push_event(EV_APPLY, id, time_left(tbl_deadline[s], now), st, notify_on);
                end
            end
            else if (!valid_slot(free_slot)) begin
                push_event(EV_APPLY, id, 32'd0, ST_FULL, 1'b0);
            end
            else begin
                insert_entry(id, lvl, dl);
                push_event(EV_APPLY, id, time_left(dl, now), ST_OK, notify_on);
            end
            made = 1;
        end
        else if (op == OP_REMOVE) begin
            s = id_active[id] ? locate_id(id) : NONE;
            if (!valid_slot(s)) begin
                push_event(EV_REMOVE, id, 32'd0, ST_NOT_ACTIVE, 1'b0);
            end
            else begin
                release_slot(s);
                push_event(EV_REMOVE, id, 32'd0, ST_OK, notify_on);
            end
            made = 1;
        end
        else if (op == OP_TICK) begin
            while (made < MAX_OUT && live_count > 0 && valid_slot(head_slot)) begin
                s = head_slot;
                if (tbl_deadline[s] == ENDLESS || tbl_deadline[s] > now) break;
                push_event(EV_REMOVE, tbl_id[s], 32'd0, ST_OK, notify_on);
                release_slot(s);
                made++;
            end
        end
        if (made > 0) expected_events[$].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n) begin
        timer_event_t got;
        timer_event_t want;
        if (!rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                tbl_id[i] = '0;
                tbl_level[i] = '0;
                tbl_deadline[i] = ENDLESS;
                tbl_next[i] = (i + 1 < NSLOT) ? 5'(i + 1) : NONE;
                tbl_prev[i] = NONE;
            end
            for (int i = 0; i < NID; i++) id_active[i] = 0;
            head_slot = '0;
            free_slot = '0;
            recent_slot = '0;
            live_count = 0;
            notify_on = 1'b1;
            expected_events.delete();
            errors = 0;
            results_seen = 0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.event_kind, rsp.result_id, rsp.remaining, rsp.status,
                        rsp.notify, rsp.last};
                results_seen++;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, got);
                    errors++;
                end
                else begin
                    want = expected_events.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_item(req.operation, req.entry_id, req.level, req.deadline,
                             req.overwrite_mode, req.current_tick);
            if (cfg.valid && cfg.ready) notify_on = cfg.notify_enable;
        end
        pending = expected_events.size();
    end

endmodule

// ===== bench/deadline_sorted_timer_table_top_test.sv =====
module deadline_sorted_timer_table_top_test;
    import dstt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   results_seen;
    int   cycle_count;
    int   items_sent;
    int   apply_count;
    int   remove_count;
    int   tick_count;
    bit   hold_off;
    logic [31:0] clock_now;

    dstt_req_if req ();
    dstt_rsp_if rsp ();
    dstt_cfg_if cfg ();

    deadline_sorted_timer_table_top dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                                         .cfg(cfg));

    deadline_sorted_timer_table_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg),
        .errors(errors), .pending(pending), .results_seen(results_seen));

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        rsp.ready = 1'b0;
        hold_off = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off) rsp.ready <= 1'b0;
            else if ($urandom_range(0, 99) < 30) rsp.ready <= 1'b0;
            else if ($urandom_range(0, 9) == 0)
                rsp.ready <= 1'b1;
            else rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("** deadline_sorted_timer_table_top: FAILED **");
                $finish;
            end
        end
    end

    // The sender leaves valid high after an accepted item; a gap or a drain drops it.
    task automatic send_item(logic [1:0] op, logic [5:0] id, logic [7:0] lvl,
                             logic [31:0] dl, logic [1:0] mode, logic [31:0] now);
        if ($urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.operation <= op;
        req.entry_id <= id;
        req.level <= lvl;
        req.deadline <= dl;
        req.overwrite_mode <= mode;
        req.current_tick <= now;
        do @(posedge clk); while (!req.ready);
        items_sent++;
        if (op == OP_APPLY) apply_count++;
        else if (op == OP_REMOVE) remove_count++;
        else if (op == OP_TICK) tick_count++;
    endtask

    task automatic drain_and_write(logic value);
        req.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.notify_enable <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_item();
        int pick;
        logic [31:0] dl;
        pick = $urandom_range(0, 99);
        dl = clock_now + $urandom_range(0, 200);
        if ($urandom_range(0, 19) == 0) dl = ENDLESS;
        else if ($urandom_range(0, 19) == 0) dl = $urandom;
        if (pick < 50)
            send_item(OP_APPLY, 6'($urandom_range(0, 23)), 8'($urandom), dl,
                      2'($urandom_range(0, 3)), clock_now);
        else if (pick < 70)
            send_item(OP_REMOVE, 6'($urandom_range(0, 23)), 8'($urandom), $urandom,
                      2'($urandom), clock_now);
        else if (pick < 97) begin
            clock_now = clock_now + $urandom_range(0, 60);
            send_item(OP_TICK, 6'($urandom), 8'($urandom), $urandom, 2'($urandom), clock_now);
        end
        else
            send_item(OP_NONE, 6'($urandom), 8'($urandom), $urandom, 2'($urandom), $urandom);
    endtask

    initial begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_TICK;
        req.entry_id = '0;
        req.level = '0;
        req.deadline = '0;
        req.overwrite_mode = MODE_ALWAYS;
        req.current_tick = '0;
        cfg.valid = 1'b0;
        cfg.notify_enable = 1'b1;
        items_sent = 0;
        apply_count = 0;
        remove_count = 0;
        tick_count = 0;
        clock_now = 32'd1000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_REMOVE, 6'd63, 8'd0, 32'd0, MODE_ALWAYS, 32'd0);
        send_item(OP_APPLY, 6'd63, 8'hFF, ENDLESS, MODE_ALWAYS, 32'hFFFF_FFFF);
        send_item(OP_APPLY, 6'd0, 8'd0, 32'd5, MODE_ALWAYS, 32'd10);
        send_item(OP_APPLY, 6'd0, 8'd9, 32'd5, MODE_ALWAYS, 32'd0);
        send_item(OP_APPLY, 6'd0, 8'd9, 32'd50, MODE_NEVER, 32'd0);
        send_item(OP_APPLY, 6'd0, 8'd9, 32'd50, MODE_AT_LEAST, 32'd0);
        send_item(OP_APPLY, 6'd0, 8'd0, 32'd50, MODE_AT_MOST, 32'd0);
        send_item(OP_APPLY, 6'd63, 8'd1, 32'd3, MODE_AT_MOST, 32'd0);
        send_item(OP_NONE, 6'd5, 8'd0, 32'd0, MODE_ALWAYS, 32'd0);
        for (int i = 1; i < 16; i++)
            send_item(OP_APPLY, 6'(i), 8'(i), 32'(i % 4), MODE_ALWAYS, 32'd0);
        send_item(OP_APPLY, 6'd40, 8'd1, 32'd1, MODE_ALWAYS, 32'd0);
        send_item(OP_TICK, 6'd0, 8'd0, 32'd0, MODE_ALWAYS, 32'hFFFF_FFFE);
        send_item(OP_TICK, 6'd0, 8'd0, 32'd0, MODE_ALWAYS, 32'hFFFF_FFFE);
        send_item(OP_REMOVE, 6'd63, 8'd0, 32'd0, MODE_ALWAYS, 32'd0);

        drain_and_write(1'b0);
        for (int i = 0; i < 100; i++) random_item();
        drain_and_write(1'b1);
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 100; i++) random_item();
        join
        drain_and_write(1'b0);
        for (int i = 0; i < 100; i++) random_item();
        drain_and_write(1'b1);

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d items (%0d apply, %0d remove, %0d tick), checked %0d results,",
                 items_sent, apply_count, remove_count, tick_count, results_seen);
        $display("with notify toggled across phases and a long receiver hold-off.");
        if (errors == 0 && pending == 0)
            $display("** deadline_sorted_timer_table_top: PASSED **");
        else
            $display("** deadline_sorted_timer_table_top: FAILED **");
        $finish;
    end

endmodule
